[src/twi_pkg.sv]
// ----------------------------------------------------------------------------
// twi_pkg - shared types and constants of the timed waypoint interpolator
// Status codes, controller states, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package twi_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam logic [31:0] SPEED_RESET = 32'd327680;  // 5.0 in Q16.16
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // last step values and step counts of the multi-cycle units
  localparam logic [5:0] AXIS_LAST = 6'd3;
  localparam logic [5:0] SQRT_LAST = 6'd33;
  localparam logic [5:0] DIV_DUR_STEPS = 6'd50;
  localparam logic [5:0] DIV_FRAC_STEPS = 6'd31;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_MOVING   = 3'd1,
    ST_FINISHED = 3'd2,
    ST_STORED   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_NEXT,
    RD_SEG
  } rd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_CHK,
    S_LD_LAT,
    S_LD_MAG,
    S_LD_SQ,
    S_LD_SQRT_INIT,
    S_LD_SQRT,
    S_LD_DIV_START,
    S_LD_DIV,
    S_LD_COMMIT,
    S_TK_CHK,
    S_TK_EL,
    S_TK_RD,
    S_TK_CMP,
    S_TK_F0,
    S_TK_F1,
    S_TK_F2,
    S_TK_FRAC,
    S_TK_DIV,
    S_TK_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    clear_path;
    logic    wr_point;
    logic    commit;
    logic    inc_count;
    rd_sel_t rd_sel;
    logic    lat_a;
    logic    lat_mag;
    logic    mag_from_in;
    logic    step_clr;
    logic    step_inc;
    logic    sq_step;
    logic    mul_step;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    div_dur;
    logic    div_frac;
    logic    frac_set;
    logic    frac_div;
    logic    tick_start;
    logic    lat_el;
    logic    seg_inc;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic       req_type;
    logic       full;
    logic       count_zero;
    logic       count_one;
    logic       seg_last;
    logic       passed;
    logic       need_div;
    logic       div_busy;
    logic       out_free;
    logic [5:0] step;
  } stat_t;

endpackage

[src/timed_waypoint_interpolator.sv]
// ----------------------------------------------------------------------------
// timed_waypoint_interpolator - constant-speed follower of a 3-D polyline
// Top level: joins the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result for
// each. A load (req_type 0) appends a Q15.16 waypoint; new_path starts a fresh
// path. Each point after the first costs a 34-step bit-serial square root of
// the squared distance and a 50-step division by travel_speed on the shared
// divider; the first point, or a drop into a full store, needs neither. A tick
// (req_type 1) carries time_now in 1/65536 s; the first tick of a path latches
// the start time. A tick walks the arrival store over each segment it passes,
// then fetches the segment, runs a 31-step fraction division when the
// fraction is at least 0 and below 1, and interpolates the three axes over
// one shared multiplier. in_ready is high only while no transaction is in
// progress; a finished result waits in the output register, and the next
// transaction is taken while it waits. A transaction that finishes while an
// earlier result still waits holds until that result is taken. Passing the
// last point, or ticking a one-point path, clears the path and reports
// finished. travel_speed may be written only while the block is idle.
// ----------------------------------------------------------------------------
module timed_waypoint_interpolator #(
  parameter int MAX_WAYPOINTS = twi_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic               new_path,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [47:0]        time_now,
  // travel speed register, Q16.16
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [5:0]         segment_index
);

  twi_pkg::cmd_t  cmd;
  twi_pkg::stat_t stat;

  // Sequencing: one state per step of the load or tick walk
  twi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, arithmetic units and the output register
  twi_dpath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .new_path      (new_path),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .time_now      (time_now),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .segment_index (segment_index)
  );

endmodule

[src/twi_div.sv]
// ----------------------------------------------------------------------------
// twi_div - restoring divider, one quotient bit per cycle
// Shared by the segment duration on a load and the segment fraction on a tick.
// ----------------------------------------------------------------------------
module twi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] dividend,
  input  logic [47:0] rem_init,
  input  logic [47:0] divisor,
  input  logic [5:0]  steps,
  output logic        busy,
  output logic [49:0] quotient
);

  logic [49:0] dvd;
  logic [47:0] rem;
  logic [47:0] dvs;
  logic [5:0]  cnt;
  logic [48:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, dvd[49]};
  assign ge = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= rem_init;
      dvs <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[48:0], 1'b0};
      quotient <= {quotient[48:0], ge};
      if (ge) begin
        rem <= 48'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[47:0];
      end
    end
  end

endmodule

[src/twi_dpath.sv]
// ----------------------------------------------------------------------------
// twi_dpath - datapath of the timed waypoint interpolator
// Waypoint and timing stores, path state, squared-distance accumulation,
// bit-serial square root, shared divider, interpolation multiplier and the
// output register.
// ----------------------------------------------------------------------------
module twi_dpath #(
  parameter int MAX_WAYPOINTS = twi_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  twi_pkg::cmd_t      cmd,
  output twi_pkg::stat_t     stat,
  input  logic               req_type,
  input  logic               new_path,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [47:0]        time_now,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [5:0]         segment_index
);

  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

  // stores
  logic [95:0] wp_mem  [MAX_WAYPOINTS];
  logic [47:0] arr_mem [MAX_WAYPOINTS];
  logic [47:0] dur_mem [MAX_WAYPOINTS];
  logic [95:0] rd_wp;
  logic [47:0] rd_arr;
  logic [47:0] rd_dur;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] cnt_a;
  logic [IDX_W-1:0] prev_a;
  logic        arr_we;
  logic [47:0] arr_wd;

  // captured transaction
  logic        req_q;
  logic [31:0] in_pt [3];
  logic [47:0] now_q;

  // path state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] seg;
  logic [CNT_W-1:0] seg_p1;
  logic             started;
  logic [47:0]      start_time;
  logic [47:0]      elapsed;
  logic [31:0]      speed;
  logic             clr;

  // working registers
  logic [31:0] pa [3];
  logic [47:0] arr_s;
  logic [47:0] dur_s;
  logic [47:0] dt_q;
  logic        late_q;
  logic [32:0] mag [3];
  logic        neg [3];
  logic [65:0] sum;
  logic [65:0] prod;
  logic [5:0]  step;
  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic [31:0] off;
  logic [1:0]  pk;
  logic [31:0] frac;

  // square root
  logic [67:0] rad;
  logic [35:0] srem;
  logic [33:0] root;
  logic [37:0] r4;
  logic [37:0] trial;
  logic        sq_ge;

  // divider
  logic        div_start;
  logic [49:0] div_dvd;
  logic [47:0] div_rem;
  logic [47:0] div_dvs;
  logic [5:0]  div_steps;
  logic [49:0] div_q;
  logic        div_busy;
  logic [47:0] dur_sat;
  logic [48:0] arr_sum;
  logic [47:0] arr_new;

  // result and output registers
  twi_pkg::status_t res_status;
  logic [31:0]      res_pos [3];
  logic [IDX_W-1:0] res_seg;
  logic [IDX_W+5:0] seg_wide;

  assign count_m1 = count - CNT_W'(1);
  assign seg_p1 = CNT_W'(seg) + CNT_W'(1);
  assign cnt_a = count[IDX_W-1:0];
  assign prev_a = count_m1[IDX_W-1:0];
  assign clr = cmd.clear_path || (cmd.capture && !req_type && new_path);

  always_comb begin
    case (cmd.rd_sel)
      twi_pkg::RD_PREV: rd_addr = prev_a;
      twi_pkg::RD_NEXT: rd_addr = seg_p1[IDX_W-1:0];
      twi_pkg::RD_SEG:  rd_addr = seg;
      default:          rd_addr = seg;
    endcase
  end

  // duration saturates to the largest time; zero speed saturates too
  assign dur_sat = (speed == '0 || div_q[49:48] != 2'b00) ? twi_pkg::TIME_MAX
                                                          : div_q[47:0];
  assign arr_sum = {1'b0, arr_s} + {1'b0, dur_sat};
  assign arr_new = arr_sum[48] ? twi_pkg::TIME_MAX : arr_sum[47:0];
  assign arr_we = (cmd.wr_point && count == '0) || cmd.commit;
  assign arr_wd = cmd.commit ? arr_new : '0;

  always_ff @(posedge clk) begin
    if (cmd.wr_point) begin
      wp_mem[cnt_a] <= {in_pt[2], in_pt[1], in_pt[0]};
    end
    if (arr_we) begin
      arr_mem[cnt_a] <= arr_wd;
    end
    if (cmd.commit) begin
      dur_mem[prev_a] <= dur_sat;
    end
    rd_wp <= wp_mem[rd_addr];
    rd_arr <= arr_mem[rd_addr];
    rd_dur <= dur_mem[rd_addr];
  end

  // path state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seg <= '0;
      started <= 1'b0;
      start_time <= '0;
      speed <= twi_pkg::SPEED_RESET;
    end else begin
      if (cfg_wr_en) begin
        speed <= cfg_wr_data;
      end
      if (clr) begin
        count <= '0;
        seg <= '0;
        started <= 1'b0;
      end else begin
        if (cmd.inc_count) begin
          count <= count + CNT_W'(1);
        end
        if (cmd.seg_inc) begin
          seg <= seg + IDX_W'(1);
        end
        if (cmd.tick_start && !started) begin
          started <= 1'b1;
          start_time <= now_q;
          seg <= '0;
        end
      end
    end
  end

  // transaction capture and working registers
  assign r4 = {srem, rad[67:66]};
  assign trial = {2'b00, root, 2'b01};
  assign sq_ge = r4 >= trial;
  assign mul_a = (step < 6'd3) ? mag[step[1:0]] : '0;
  assign mul_b = cmd.sq_step ? mul_a : {1'b0, frac};
  assign pk = 2'(step - 6'd1);
  assign off = prod[62:31];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      in_pt[0] <= point_x;
      in_pt[1] <= point_y;
      in_pt[2] <= point_z;
      now_q <= time_now;
    end
    if (cmd.lat_el) begin
      elapsed <= (now_q >= start_time) ? 48'(now_q - start_time) : '0;
    end
    if (cmd.lat_a) begin
      for (int k = 0; k < 3; k++) begin
        pa[k] <= rd_wp[32*k +: 32];
      end
      arr_s <= rd_arr;
      dur_s <= rd_dur;
    end
    if (cmd.lat_mag) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [32:0] d;
        d = cmd.mag_from_in ? ($signed({in_pt[k][31], in_pt[k]}) -
                               $signed({pa[k][31], pa[k]}))
                            : ($signed({rd_wp[32*k+31], rd_wp[32*k +: 32]}) -
                               $signed({pa[k][31], pa[k]}));
        neg[k] <= d[32];
        mag[k] <= d[32] ? 33'(-d) : 33'(d);
      end
      dt_q <= 48'(elapsed - arr_s);
      late_q <= elapsed < arr_s;
      sum <= '0;
      prod <= '0;
    end
    if (cmd.step_clr) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + 6'd1;
    end
    if (cmd.sq_step || cmd.mul_step) begin
      prod <= 66'(mul_a * mul_b);
    end
    if (cmd.sq_step) begin
      sum <= sum + prod;
    end
    if (cmd.mul_step && step != '0) begin
      res_pos[pk] <= neg[pk] ? 32'(pa[pk] - off) : 32'(pa[pk] + off);
    end
    if (cmd.sqrt_init) begin
      rad <= {2'b00, sum};
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[65:0], 2'b00};
      root <= {root[32:0], sq_ge};
      srem <= sq_ge ? 36'(r4 - trial) : r4[35:0];
    end
    if (cmd.frac_set) begin
      frac <= (dur_s == '0) ? '0 : 32'h8000_0000;
    end else if (cmd.frac_div) begin
      frac <= {1'b0, div_q[30:0]};
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
      if (cmd.status_code == twi_pkg::ST_MOVING) begin
        res_seg <= seg;
      end else begin
        res_seg <= '0;
        for (int k = 0; k < 3; k++) begin
          res_pos[k] <= '0;
        end
      end
    end
  end

  // divider operands: duration on a load, fraction on a tick
  assign div_start = cmd.div_dur || cmd.div_frac;
  assign div_dvd = cmd.div_dur ? {root, 16'h0000} : '0;
  assign div_rem = cmd.div_dur ? '0 : dt_q;
  assign div_dvs = cmd.div_dur ? {16'h0000, speed} : dur_s;
  assign div_steps = cmd.div_dur ? twi_pkg::DIV_DUR_STEPS : twi_pkg::DIV_FRAC_STEPS;

  twi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .rem_init (div_rem),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // output register
  assign seg_wide = {6'b000000, res_seg};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      pos_x <= res_pos[0];
      pos_y <= res_pos[1];
      pos_z <= res_pos[2];
      segment_index <= seg_wide[5:0];
    end
  end

  always_comb begin
    stat.req_type = req_q;
    stat.full = count >= CNT_W'(MAX_WAYPOINTS);
    stat.count_zero = count == '0;
    stat.count_one = count == CNT_W'(1);
    stat.seg_last = seg_p1 >= count;
    stat.passed = elapsed > rd_arr;
    stat.need_div = dur_s != '0 && !late_q && dt_q < dur_s;
    stat.div_busy = div_busy;
    stat.out_free = !out_valid || out_ready;
    stat.step = step;
  end

endmodule

[src/twi_ctrl.sv]
// ----------------------------------------------------------------------------
// twi_ctrl - sequencing state machine of the timed waypoint interpolator
// Walks a load through distance, square root and division, and a tick through
// segment advance, fraction and interpolation.
// ----------------------------------------------------------------------------
module twi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           req_type,
  input  twi_pkg::stat_t stat,
  output twi_pkg::cmd_t  cmd
);

  twi_pkg::state_t state;
  twi_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == twi_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      twi_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = req_type ? twi_pkg::S_TK_CHK : twi_pkg::S_LD_CHK;
        end
      end
      twi_pkg::S_LD_CHK: begin
        if (stat.full || stat.count_zero) begin
          state_next = twi_pkg::S_DONE;
        end else begin
          state_next = twi_pkg::S_LD_LAT;
        end
      end
      twi_pkg::S_LD_LAT:       state_next = twi_pkg::S_LD_MAG;
      twi_pkg::S_LD_MAG:       state_next = twi_pkg::S_LD_SQ;
      twi_pkg::S_LD_SQ: begin
        if (stat.step == twi_pkg::AXIS_LAST) begin
          state_next = twi_pkg::S_LD_SQRT_INIT;
        end
      end
      twi_pkg::S_LD_SQRT_INIT: state_next = twi_pkg::S_LD_SQRT;
      twi_pkg::S_LD_SQRT: begin
        if (stat.step == twi_pkg::SQRT_LAST) begin
          state_next = twi_pkg::S_LD_DIV_START;
        end
      end
      twi_pkg::S_LD_DIV_START: state_next = twi_pkg::S_LD_DIV;
      twi_pkg::S_LD_DIV: begin
        if (!stat.div_busy) begin
          state_next = twi_pkg::S_LD_COMMIT;
        end
      end
      twi_pkg::S_LD_COMMIT:    state_next = twi_pkg::S_DONE;
      twi_pkg::S_TK_CHK: begin
        if (stat.count_zero || stat.count_one) begin
          state_next = twi_pkg::S_DONE;
        end else begin
          state_next = twi_pkg::S_TK_EL;
        end
      end
      twi_pkg::S_TK_EL:        state_next = twi_pkg::S_TK_RD;
      twi_pkg::S_TK_RD: begin
        state_next = stat.seg_last ? twi_pkg::S_DONE : twi_pkg::S_TK_CMP;
      end
      twi_pkg::S_TK_CMP: begin
        state_next = stat.passed ? twi_pkg::S_TK_RD : twi_pkg::S_TK_F0;
      end
      twi_pkg::S_TK_F0:        state_next = twi_pkg::S_TK_F1;
      twi_pkg::S_TK_F1:        state_next = twi_pkg::S_TK_F2;
      twi_pkg::S_TK_F2:        state_next = twi_pkg::S_TK_FRAC;
      twi_pkg::S_TK_FRAC: begin
        state_next = stat.need_div ? twi_pkg::S_TK_DIV : twi_pkg::S_TK_MUL;
      end
      twi_pkg::S_TK_DIV: begin
        if (!stat.div_busy) begin
          state_next = twi_pkg::S_TK_MUL;
        end
      end
      twi_pkg::S_TK_MUL: begin
        if (stat.step == twi_pkg::AXIS_LAST) begin
          state_next = twi_pkg::S_DONE;
        end
      end
      twi_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = twi_pkg::S_IDLE;
        end
      end
      default: state_next = twi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = twi_pkg::RD_PREV;
    cmd.status_code = twi_pkg::ST_IDLE;
    case (state)
      twi_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      twi_pkg::S_LD_CHK: begin
        cmd.set_status = stat.full || stat.count_zero;
        if (stat.full) begin
          cmd.status_code = twi_pkg::ST_FULL;
        end else begin
          cmd.wr_point = 1'b1;
          cmd.status_code = twi_pkg::ST_STORED;
          cmd.inc_count = stat.count_zero;
        end
      end
      twi_pkg::S_LD_LAT: begin
        cmd.lat_a = 1'b1;
      end
      twi_pkg::S_LD_MAG: begin
        cmd.lat_mag = 1'b1;
        cmd.mag_from_in = 1'b1;
        cmd.step_clr = 1'b1;
      end
      twi_pkg::S_LD_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.step_inc = 1'b1;
      end
      twi_pkg::S_LD_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cmd.step_clr = 1'b1;
      end
      twi_pkg::S_LD_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.step_inc = 1'b1;
      end
      twi_pkg::S_LD_DIV_START: begin
        cmd.div_dur = 1'b1;
      end
      twi_pkg::S_LD_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.inc_count = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status_code = twi_pkg::ST_STORED;
      end
      twi_pkg::S_TK_CHK: begin
        if (stat.count_zero) begin
          cmd.set_status = 1'b1;
          cmd.status_code = twi_pkg::ST_IDLE;
        end else if (stat.count_one) begin
          cmd.clear_path = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_code = twi_pkg::ST_FINISHED;
        end else begin
          cmd.tick_start = 1'b1;
        end
      end
      twi_pkg::S_TK_EL: begin
        cmd.lat_el = 1'b1;
      end
      twi_pkg::S_TK_RD: begin
        cmd.rd_sel = twi_pkg::RD_NEXT;
        if (stat.seg_last) begin
          cmd.clear_path = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_code = twi_pkg::ST_FINISHED;
        end
      end
      twi_pkg::S_TK_CMP: begin
        cmd.seg_inc = stat.passed;
      end
      twi_pkg::S_TK_F0: begin
        cmd.rd_sel = twi_pkg::RD_SEG;
      end
      twi_pkg::S_TK_F1: begin
        cmd.lat_a = 1'b1;
        cmd.rd_sel = twi_pkg::RD_NEXT;
      end
      twi_pkg::S_TK_F2: begin
        cmd.lat_mag = 1'b1;
      end
      twi_pkg::S_TK_FRAC: begin
        if (stat.need_div) begin
          cmd.div_frac = 1'b1;
        end else begin
          cmd.frac_set = 1'b1;
          cmd.step_clr = 1'b1;
        end
      end
      twi_pkg::S_TK_DIV: begin
        if (!stat.div_busy) begin
          cmd.frac_div = 1'b1;
          cmd.step_clr = 1'b1;
        end
      end
      twi_pkg::S_TK_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.step_inc = 1'b1;
        if (stat.step == twi_pkg::AXIS_LAST) begin
          cmd.set_status = 1'b1;
          cmd.status_code = twi_pkg::ST_MOVING;
        end
      end
      twi_pkg::S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
